// ----- hdl/sdd_pkg.sv -----
// Shared types, widths, register indexes and saturation helper for the density relaxation block.
package sdd_pkg;

  localparam int CNT_W      = 6;
  localparam int X_W        = 16;
  localparam int W_W        = 17;
  localparam int SUM_W      = 24;
  localparam int P_W        = 43;
  localparam int T_W        = 61;
  localparam int C_W        = 38;
  localparam int M_W        = 39;
  localparam int H_W        = 38;
  localparam int CTR_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_DENSITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SQUARED = 2'd3;

  localparam logic signed [CTR_W-1:0] SAT_HI = 48'sd32767;
  localparam logic signed [CTR_W-1:0] SAT_LO = -48'sd32768;

  typedef struct packed {
    logic acc_take;
    logic wgt_start_rd;
    logic rd;
    logic w2_ld;
    logic sum_add;
    logic p_ld;
    logic pn_ld;
    logic t1_ld;
    logic t2_ld;
    logic c_ld;
    logic m_ld;
    logic hx_ld;
    logic hy_ld;
    logic h_zero;
    logic out_ld_nb;
    logic out_ld_ctr;
    logic idx_inc;
    logic run_clr;
  } sdd_cmd_t;

  typedef struct packed {
    logic wgt_done;
    logic wgt_ok;
    logic full;
    logic more;
  } sdd_stat_t;

  typedef struct packed {
    logic [X_W-1:0] val;
    logic           ovf;
  } sdd_sat_t;

  function automatic sdd_sat_t sat16(input logic signed [CTR_W-1:0] v);
    sdd_sat_t r;
    if (v > SAT_HI) begin
      r.val = 16'h7fff;
      r.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = 16'h8000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[X_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/sdd_wgt.sv -----
// Iterative weight unit: squared length, bitwise square root, restoring divide, w = 1 - q.
module sdd_wgt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [sdd_pkg::X_W-1:0] x,
  input  logic signed [sdd_pkg::X_W-1:0] y,
  input  logic [14:0]                 rad,
  output logic                        done,
  output logic                        ok,
  output logic [sdd_pkg::W_W-1:0]     w
);

  localparam logic [2:0] WS_IDLE = 3'd0;
  localparam logic [2:0] WS_SQX  = 3'd1;
  localparam logic [2:0] WS_SQY  = 3'd2;
  localparam logic [2:0] WS_ROOT = 3'd3;
  localparam logic [2:0] WS_CHK  = 3'd4;
  localparam logic [2:0] WS_DIV  = 3'd5;
  localparam logic [2:0] WS_FIN  = 3'd6;

  logic [2:0]                 st_r, st_nxt;
  logic signed [15:0]         x_r, y_r;
  logic [14:0]                rad_r;
  logic [31:0]                sq_r, v_r, res_r;
  logic [4:0]                 k_r;
  logic [16:0]                rem_r, q_r;

  logic signed [31:0]         xx, yy;
  logic [31:0]                bit_w, trial;
  logic [15:0]                len;
  logic                       miss;
  logic                       ge;
  logic [16:0]                rem_sub, rem_sel;

  assign xx      = x_r * x_r;
  assign yy      = y_r * y_r;
  assign bit_w   = 32'd1 << {k_r[3:0], 1'b0};
  assign trial   = res_r + bit_w;
  assign len     = res_r[15:0];
  assign miss    = (len == 16'd0) || (len > {1'b0, rad_r});
  assign ge      = rem_r >= {2'b00, rad_r};
  assign rem_sub = rem_r - {2'b00, rad_r};
  assign rem_sel = ge ? rem_sub : rem_r;

  assign done = ((st_r == WS_CHK) && miss) || (st_r == WS_FIN);
  assign ok   = (st_r == WS_FIN);
  assign w    = 17'h10000 - q_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      WS_IDLE: if (start) st_nxt = WS_SQX;
      WS_SQX:  st_nxt = WS_SQY;
      WS_SQY:  st_nxt = WS_ROOT;
      WS_ROOT: if (k_r == 5'd0) st_nxt = WS_CHK;
      WS_CHK:  st_nxt = miss ? WS_IDLE : WS_DIV;
      WS_DIV:  if (k_r == 5'd0) st_nxt = WS_FIN;
      WS_FIN:  st_nxt = WS_IDLE;
      default: st_nxt = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= WS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      WS_IDLE: begin
        if (start) begin
          x_r   <= x;
          y_r   <= y;
          rad_r <= rad;
        end
      end
      WS_SQX: sq_r <= xx;
      WS_SQY: begin
        v_r   <= sq_r + yy;
        res_r <= 32'd0;
        k_r   <= 5'd15;
      end
      WS_ROOT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_w;
        end else begin
          res_r <= res_r >> 1;
        end
        k_r <= k_r - 5'd1;
      end
      WS_CHK: begin
        rem_r <= {1'b0, len};
        q_r   <= 17'd0;
        k_r   <= 5'd16;
      end
      WS_DIV: begin
        rem_r <= {rem_sel[15:0], 1'b0};
        q_r   <= {q_r[15:0], ge};
        k_r   <= k_r - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/sdd_dp.sv -----
// Datapath: offset store, density sums, pressure products, per-neighbour moves, result register.
module sdd_dp #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdd_pkg::sdd_cmd_t             cmd,
  output sdd_pkg::sdd_stat_t            stat,
  input  logic signed [sdd_pkg::X_W-1:0] in_x,
  input  logic signed [sdd_pkg::X_W-1:0] in_y,
  input  logic [16:0]                   stiffness,
  input  logic [12:0]                   rest_density,
  input  logic [14:0]                   radius,
  input  logic [23:0]                   step_squared,
  output logic [sdd_pkg::X_W-1:0]       out_move_x,
  output logic [sdd_pkg::X_W-1:0]       out_move_y,
  output logic [sdd_pkg::CNT_W-1:0]     out_slot,
  output logic                          out_is_centre,
  output logic                          out_overflow
);

  localparam int IW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam logic [sdd_pkg::CNT_W-1:0] MAX_CNT = sdd_pkg::CNT_W'(MAX_NEIGHBOURS);

  logic [31:0] store_mem [MAX_NEIGHBOURS];
  logic [31:0] rd_r;

  logic [sdd_pkg::CNT_W-1:0]   count_r, idx_r;
  logic                        dropped_r;
  logic [sdd_pkg::SUM_W-1:0]   dens_r, near_r;
  logic [sdd_pkg::W_W-1:0]     w2_r;
  logic signed [sdd_pkg::P_W-1:0]   p_r, pn_r;
  logic signed [sdd_pkg::T_W-1:0]   t1_r, t2_r;
  logic signed [sdd_pkg::C_W-1:0]   c_r;
  logic signed [sdd_pkg::M_W-1:0]   m_r;
  logic signed [sdd_pkg::H_W-1:0]   hx_r, hy_r;
  logic signed [sdd_pkg::CTR_W-1:0] cx_r, cy_r;

  logic                        full;
  logic                        wgt_start;
  logic signed [15:0]          rd_x, rd_y, wx, wy;
  logic                        wgt_done, wgt_ok;
  logic [sdd_pkg::W_W-1:0]     wgt_w;
  logic [33:0]                 ww, w2w;
  logic [sdd_pkg::W_W-1:0]     w2_c, w3_c;
  logic signed [24:0]          diff;
  logic signed [17:0]          stiff_s;
  logic signed [sdd_pkg::P_W-1:0] p_c, pn_c;
  logic signed [sdd_pkg::T_W-1:0] t1_c, t2_c;
  logic signed [sdd_pkg::T_W:0]   tsum;
  logic signed [62:0]          cm;
  logic signed [54:0]          mx, my;
  logic signed [sdd_pkg::CTR_W-1:0] hx_e, hy_e;
  sdd_pkg::sdd_sat_t           sat_x, sat_y, sat_cx, sat_cy;

  assign full      = count_r >= MAX_CNT;
  assign rd_x      = rd_r[15:0];
  assign rd_y      = rd_r[31:16];
  assign wgt_start = (cmd.acc_take && !full) || cmd.wgt_start_rd;
  assign wx        = cmd.wgt_start_rd ? rd_x : in_x;
  assign wy        = cmd.wgt_start_rd ? rd_y : in_y;

  sdd_wgt u_wgt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wgt_start),
    .x     (wx),
    .y     (wy),
    .rad   (radius),
    .done  (wgt_done),
    .ok    (wgt_ok),
    .w     (wgt_w)
  );

  assign ww    = wgt_w * wgt_w;
  assign w2_c  = ww[32:16];
  assign w2w   = w2_r * wgt_w;
  assign w3_c  = w2w[32:16];

  assign stiff_s = $signed({1'b0, stiffness});
  assign diff    = $signed({1'b0, dens_r}) - $signed({4'b0000, rest_density, 8'h00});
  assign p_c     = stiff_s * diff;
  assign pn_c    = stiff_s * $signed({1'b0, near_r});
  assign t1_c    = p_r * $signed({1'b0, wgt_w});
  assign t2_c    = pn_r * $signed({1'b0, w2_r});
  assign tsum    = {t1_r[sdd_pkg::T_W-1], t1_r} + {t2_r[sdd_pkg::T_W-1], t2_r};
  assign cm      = c_r * $signed({1'b0, step_squared});
  assign mx      = m_r * rd_x;
  assign my      = m_r * rd_y;

  assign hx_e   = sdd_pkg::CTR_W'(hx_r);
  assign hy_e   = sdd_pkg::CTR_W'(hy_r);
  assign sat_x  = sdd_pkg::sat16(hx_e);
  assign sat_y  = sdd_pkg::sat16(hy_e);
  assign sat_cx = sdd_pkg::sat16(cx_r);
  assign sat_cy = sdd_pkg::sat16(cy_r);

  assign stat.wgt_done = wgt_done;
  assign stat.wgt_ok   = wgt_ok;
  assign stat.full     = full;
  assign stat.more     = idx_r < count_r;

  always_ff @(posedge clk) begin
    if (cmd.acc_take && !full) store_mem[count_r[IW-1:0]] <= {in_y, in_x};
    if (cmd.rd) rd_r <= store_mem[idx_r[IW-1:0]];
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      dropped_r <= 1'b0;
      dens_r    <= '0;
      near_r    <= '0;
      cx_r      <= '0;
      cy_r      <= '0;
    end else if (cmd.run_clr) begin
      count_r   <= '0;
      idx_r     <= '0;
      dropped_r <= 1'b0;
      dens_r    <= '0;
      near_r    <= '0;
      cx_r      <= '0;
      cy_r      <= '0;
    end else begin
      if (cmd.acc_take) begin
        if (full) dropped_r <= 1'b1;
        else count_r <= count_r + 1'b1;
      end
      if (cmd.sum_add) begin
        dens_r <= dens_r + sdd_pkg::SUM_W'(w2_r);
        near_r <= near_r + sdd_pkg::SUM_W'(w3_c);
      end
      if (cmd.pn_ld) begin
        idx_r <= '0;
        cx_r  <= '0;
        cy_r  <= '0;
      end
      if (cmd.out_ld_nb) begin
        cx_r <= cx_r - hx_e;
        cy_r <= cy_r - hy_e;
      end
      if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.w2_ld) w2_r <= w2_c;
    if (cmd.p_ld)  p_r  <= p_c;
    if (cmd.pn_ld) pn_r <= pn_c;
    if (cmd.t1_ld) t1_r <= t1_c;
    if (cmd.t2_ld) t2_r <= t2_c;
    if (cmd.c_ld)  c_r  <= sdd_pkg::C_W'(tsum >>> 24);
    if (cmd.m_ld)  m_r  <= sdd_pkg::M_W'(cm >>> 24);
    if (cmd.hx_ld) hx_r <= sdd_pkg::H_W'(mx >>> 17);
    if (cmd.hy_ld) hy_r <= sdd_pkg::H_W'(my >>> 17);
    if (cmd.h_zero) begin
      hx_r <= '0;
      hy_r <= '0;
    end
    if (cmd.out_ld_nb) begin
      out_move_x    <= sat_x.val;
      out_move_y    <= sat_y.val;
      out_slot      <= idx_r;
      out_is_centre <= 1'b0;
      out_overflow  <= dropped_r | sat_x.ovf | sat_y.ovf;
    end
    if (cmd.out_ld_ctr) begin
      out_move_x    <= sat_cx.val;
      out_move_y    <= sat_cy.val;
      out_slot      <= count_r;
      out_is_centre <= 1'b1;
      out_overflow  <= dropped_r | sat_cx.ovf | sat_cy.ovf;
    end
  end

endmodule

// ----- hdl/sdd_ctrl.sv -----
// Controller: sequences accumulation per offset and the result run after the final offset.
module sdd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_final_offset,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sdd_pkg::sdd_stat_t   stat,
  output sdd_pkg::sdd_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ACC_W   = 5'd1;
  localparam logic [4:0] S_ACC_W2  = 5'd2;
  localparam logic [4:0] S_ACC_ADD = 5'd3;
  localparam logic [4:0] S_PREP_P  = 5'd4;
  localparam logic [4:0] S_PREP_PN = 5'd5;
  localparam logic [4:0] S_NEXT    = 5'd6;
  localparam logic [4:0] S_E_ST    = 5'd7;
  localparam logic [4:0] S_E_W     = 5'd8;
  localparam logic [4:0] S_E_W2    = 5'd9;
  localparam logic [4:0] S_E_T1    = 5'd10;
  localparam logic [4:0] S_E_T2    = 5'd11;
  localparam logic [4:0] S_E_C     = 5'd12;
  localparam logic [4:0] S_E_M     = 5'd13;
  localparam logic [4:0] S_E_HX    = 5'd14;
  localparam logic [4:0] S_E_HY    = 5'd15;
  localparam logic [4:0] S_E_OUT   = 5'd16;
  localparam logic [4:0] S_E_WAIT  = 5'd17;
  localparam logic [4:0] S_C_WAIT  = 5'd18;

  logic [4:0] st_r, st_nxt;
  logic       fin_r, fin_nxt;
  logic       accept;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_E_WAIT) || (st_r == S_C_WAIT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    st_nxt  = st_r;
    fin_nxt = fin_r;
    cmd     = '0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          cmd.acc_take = 1'b1;
          fin_nxt      = in_final_offset;
          if (!stat.full) st_nxt = S_ACC_W;
          else if (in_final_offset) st_nxt = S_PREP_P;
        end
      end
      S_ACC_W: begin
        if (stat.wgt_done) begin
          if (stat.wgt_ok) st_nxt = S_ACC_W2;
          else st_nxt = fin_r ? S_PREP_P : S_IDLE;
        end
      end
      S_ACC_W2: begin
        cmd.w2_ld = 1'b1;
        st_nxt    = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        cmd.sum_add = 1'b1;
        st_nxt      = fin_r ? S_PREP_P : S_IDLE;
      end
      S_PREP_P: begin
        cmd.p_ld = 1'b1;
        st_nxt   = S_PREP_PN;
      end
      S_PREP_PN: begin
        cmd.pn_ld = 1'b1;
        st_nxt    = S_NEXT;
      end
      S_NEXT: begin
        if (stat.more) begin
          cmd.rd = 1'b1;
          st_nxt = S_E_ST;
        end else begin
          cmd.out_ld_ctr = 1'b1;
          st_nxt         = S_C_WAIT;
        end
      end
      S_E_ST: begin
        cmd.wgt_start_rd = 1'b1;
        st_nxt           = S_E_W;
      end
      S_E_W: begin
        if (stat.wgt_done) begin
          if (stat.wgt_ok) begin
            st_nxt = S_E_W2;
          end else begin
            cmd.h_zero = 1'b1;
            st_nxt     = S_E_OUT;
          end
        end
      end
      S_E_W2: begin
        cmd.w2_ld = 1'b1;
        st_nxt    = S_E_T1;
      end
      S_E_T1: begin
        cmd.t1_ld = 1'b1;
        st_nxt    = S_E_T2;
      end
      S_E_T2: begin
        cmd.t2_ld = 1'b1;
        st_nxt    = S_E_C;
      end
      S_E_C: begin
        cmd.c_ld = 1'b1;
        st_nxt   = S_E_M;
      end
      S_E_M: begin
        cmd.m_ld = 1'b1;
        st_nxt   = S_E_HX;
      end
      S_E_HX: begin
        cmd.hx_ld = 1'b1;
        st_nxt    = S_E_HY;
      end
      S_E_HY: begin
        cmd.hy_ld = 1'b1;
        st_nxt    = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.out_ld_nb = 1'b1;
        st_nxt        = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (out_ready) begin
          cmd.idx_inc = 1'b1;
          st_nxt      = S_NEXT;
        end
      end
      S_C_WAIT: begin
        if (out_ready) begin
          cmd.run_clr = 1'b1;
          fin_nxt     = 1'b0;
          st_nxt      = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      fin_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result beat is pending");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.wgt_done |-> (st_r == S_ACC_W || st_r == S_E_W))
    else $error("weight unit finished outside a wait state");

  a_centre_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_C_WAIT && out_ready) |=> (st_r == S_IDLE && !stat.more))
    else $error("run state not cleared after centre beat");

endmodule

// ----- hdl/sph_double_density_relaxation.sv -----
// Top level: configuration registers, controller and datapath of the density relaxation block.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_offset_x, in_offset_y, in_final_offset
//   out_     output     out_valid / out_ready  out_move_x, out_move_y, out_slot,
//                                              out_is_centre, out_overflow
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// An offset inside the radius goes through 2 squaring, 16 root and 17 divide steps in the
// shared weight unit, then two weight products; one outside the radius skips the divide.
// After the final offset: two pressure products, then per neighbour a second pass through
// the weight unit and seven product steps (none outside the radius), plus output wait.
// One item at a time; in_ready is low until its results, if any, are all taken.
// Reset is synchronous and needs no clearing pass; out_ready low simply holds the beat.
module sph_double_density_relaxation #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sdd_pkg::X_W-1:0]      in_offset_x,
  input  logic signed [sdd_pkg::X_W-1:0]      in_offset_y,
  input  logic                                in_final_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sdd_pkg::X_W-1:0]      out_move_x,
  output logic signed [sdd_pkg::X_W-1:0]      out_move_y,
  output logic [sdd_pkg::CNT_W-1:0]           out_slot,
  output logic                                out_is_centre,
  output logic                                out_overflow,
  input  logic                                cfg_we,
  input  logic [sdd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [16:0] stiffness_r;
  logic [12:0] rest_density_r;
  logic [14:0] radius_r;
  logic [23:0] step_squared_r;

  sdd_pkg::sdd_cmd_t  cmd;
  sdd_pkg::sdd_stat_t stat;
  logic [sdd_pkg::X_W-1:0] mx, my;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r    <= 17'd35840;
      rest_density_r <= 13'd512;
      radius_r       <= 15'd2048;
      step_squared_r <= 24'd11341;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdd_pkg::REG_STIFFNESS:    stiffness_r    <= cfg_wdata[16:0];
        sdd_pkg::REG_REST_DENSITY: rest_density_r <= cfg_wdata[12:0];
        sdd_pkg::REG_RADIUS:       radius_r       <= cfg_wdata[14:0];
        sdd_pkg::REG_STEP_SQUARED: step_squared_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sdd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_offset (in_final_offset),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .stat            (stat),
    .cmd             (cmd)
  );

  sdd_dp #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_x          (in_offset_x),
    .in_y          (in_offset_y),
    .stiffness     (stiffness_r),
    .rest_density  (rest_density_r),
    .radius        (radius_r),
    .step_squared  (step_squared_r),
    .out_move_x    (mx),
    .out_move_y    (my),
    .out_slot      (out_slot),
    .out_is_centre (out_is_centre),
    .out_overflow  (out_overflow)
  );

  assign out_move_x = $signed(mx);
  assign out_move_y = $signed(my);

endmodule

// ----- test/sdd_move_checker.sv -----
`timescale 1ns / 1ps
// Bit-accurate move predictor and scoreboard for the density relaxation block.
module sdd_move_checker #(
  parameter int MAX_NB = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [sdd_pkg::X_W-1:0] in_offset_x,
  input  logic signed [sdd_pkg::X_W-1:0] in_offset_y,
  input  logic                           in_final_offset,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [sdd_pkg::X_W-1:0] out_move_x,
  input  logic signed [sdd_pkg::X_W-1:0] out_move_y,
  input  logic [sdd_pkg::CNT_W-1:0]      out_slot,
  input  logic                           out_is_centre,
  input  logic                           out_overflow,
  input  logic                           cfg_we,
  input  logic [sdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             moves_pending
);

  typedef struct {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [5:0]         slot;
    logic               centre;
    logic               ovf;
  } move_t;

  move_t move_q[$];

  logic [16:0] k_stiff;
  logic [12:0] k_rest;
  logic [14:0] k_rad;
  logic [23:0] k_dt2;

  logic signed [15:0] nb_x[MAX_NB];
  logic signed [15:0] nb_y[MAX_NB];
  int          nb_cnt;
  logic [23:0] dens, ndens;
  logic        dropped;

  assign moves_pending = move_q.size();

  function automatic longint isqrt(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // 1-q in Q0.16; returns 0 when the neighbour does not count
  function automatic bit one_minus_q(longint x, longint y, longint rad, output longint w);
    longint len;
    len = isqrt(x * x + y * y);
    w = 0;
    if (len == 0 || len > rad) return 0;
    w = 65536 - ((len << 16) / rad);
    return 1;
  endfunction

  function automatic logic signed [15:0] clip16(longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  task automatic predict_moves();
    longint p, pn, w, w2, c, m, hx, hy, sum_x, sum_y;
    move_t  e;
    p  = longint'(k_stiff) * (longint'(dens) - (longint'(k_rest) << 8));
    pn = longint'(k_stiff) * longint'(ndens);
    sum_x = 0;
    sum_y = 0;
    for (int i = 0; i < nb_cnt; i++) begin
      hx = 0;
      hy = 0;
      if (one_minus_q(nb_x[i], nb_y[i], k_rad, w)) begin
        w2 = (w * w) >> 16;
        c  = (p * w + pn * w2) >>> 24;
        m  = (c * longint'(k_dt2)) >>> 24;
        hx = (m * longint'(nb_x[i])) >>> 17;
        hy = (m * longint'(nb_y[i])) >>> 17;
      end
      sum_x -= hx;
      sum_y -= hy;
      e.ovf    = dropped;
      e.mx     = clip16(hx, e.ovf);
      e.my     = clip16(hy, e.ovf);
      e.slot   = i[5:0];
      e.centre = 1'b0;
      move_q.push_back(e);
    end
    e.ovf    = dropped;
    e.mx     = clip16(sum_x, e.ovf);
    e.my     = clip16(sum_y, e.ovf);
    e.slot   = nb_cnt[5:0];
    e.centre = 1'b1;
    move_q.push_back(e);
  endtask

  always @(posedge clk) begin
    longint w, w2, w3;
    move_t  e;
    if (!rst_n) begin
      k_stiff = 17'd35840;
      k_rest  = 13'd512;
      k_rad   = 15'd2048;
      k_dt2   = 24'd11341;
      nb_cnt  = 0;
      dens    = '0;
      ndens   = '0;
      dropped = 1'b0;
      fail_count = 0;
      move_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sdd_pkg::REG_STIFFNESS:    k_stiff = cfg_wdata[16:0];
          sdd_pkg::REG_REST_DENSITY: k_rest  = cfg_wdata[12:0];
          sdd_pkg::REG_RADIUS:       k_rad   = cfg_wdata[14:0];
          sdd_pkg::REG_STEP_SQUARED: k_dt2   = cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (nb_cnt < MAX_NB) begin
          nb_x[nb_cnt] = in_offset_x;
          nb_y[nb_cnt] = in_offset_y;
          nb_cnt++;
          if (one_minus_q(in_offset_x, in_offset_y, k_rad, w)) begin
            w2 = (w * w) >> 16;
            w3 = (w2 * w) >> 16;
            dens  = dens + w2[23:0];
            ndens = ndens + w3[23:0];
          end
        end else begin
          dropped = 1'b1;
        end
        if (in_final_offset) begin
          predict_moves();
          nb_cnt  = 0;
          dens    = '0;
          ndens   = '0;
          dropped = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (move_q.size() == 0) begin
          $error("unexpected move beat: slot %0d", out_slot);
          fail_count++;
        end else begin
          e = move_q.pop_front();
          if (out_move_x !== e.mx) begin
            $error("move_x: expected %0d, got %0d", e.mx, out_move_x);
            fail_count++;
          end
          if (out_move_y !== e.my) begin
            $error("move_y: expected %0d, got %0d", e.my, out_move_y);
            fail_count++;
          end
          if (out_slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, out_slot);
            fail_count++;
          end
          if (out_is_centre !== e.centre) begin
            $error("is_centre: expected %0d, got %0d", e.centre, out_is_centre);
            fail_count++;
          end
          if (out_overflow !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, out_overflow);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_sph_double_density_relaxation.sv -----
`timescale 1ns / 1ps
// Stimulus, watchdog and verdict for the density relaxation block.
module tb_sph_double_density_relaxation;

  localparam int MAX_NB    = 32;
  localparam int STALL_MAX = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_final_offset;
  logic signed [sdd_pkg::X_W-1:0] in_offset_x, in_offset_y;
  logic out_valid, out_ready, out_is_centre, out_overflow;
  logic signed [sdd_pkg::X_W-1:0] out_move_x, out_move_y;
  logic [sdd_pkg::CNT_W-1:0] out_slot;
  logic cfg_we;
  logic [sdd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdd_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int fails, pending, n_items, stall_cycles;
  bit gaps_on, hold_req;
  logic [14:0] cur_rad;

  sph_double_density_relaxation #(.MAX_NEIGHBOURS(MAX_NB)) u_dut (.*);

  sdd_move_checker #(.MAX_NB(MAX_NB)) u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_offset_x, .in_offset_y, .in_final_offset,
    .out_valid, .out_ready, .out_move_x, .out_move_y, .out_slot, .out_is_centre,
    .out_overflow, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count(fails), .moves_pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request once results show up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && out_valid) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !gaps_on || ($urandom_range(99) >= 30);
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_offset(logic signed [15:0] x, logic signed [15:0] y, logic fin);
    if (gaps_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_offset_x     <= x;
    in_offset_y     <= y;
    in_final_offset <= fin;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    n_items++;
  endtask

  // block is idle once all moves are out; a short pause covers the tail
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [sdd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[sdd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == sdd_pkg::REG_RADIUS) cur_rad = val[14:0];
  endtask

  task automatic set_regs(int unsigned k, int unsigned rho, int unsigned rad, int unsigned dt2);
    write_reg(sdd_pkg::REG_STIFFNESS, k);
    write_reg(sdd_pkg::REG_REST_DENSITY, rho);
    write_reg(sdd_pkg::REG_RADIUS, rad);
    write_reg(sdd_pkg::REG_STEP_SQUARED, dt2);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] near_coord();
    int r;
    r = (cur_rad < 4) ? 4 : cur_rad;
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(2 * r) - r);
  endfunction

  task automatic random_run(int len);
    for (int i = 0; i < len; i++)
      send_offset(near_coord(), near_coord(), i == len - 1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_offset_x = '0;
    in_offset_y = '0;
    in_final_offset = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    n_items = 0;
    cur_rad = 15'd2048;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero, inside and outside the radius, single-offset runs
    send_offset(16'sh7fff, 16'sh7fff, 1'b0);
    send_offset(-16'sh8000, -16'sh8000, 1'b0);
    send_offset(16'sh0000, 16'sh0000, 1'b0);
    send_offset(16'sh0400, -16'sh0200, 1'b0);
    send_offset(16'sh0800, 16'sh0000, 1'b0);
    send_offset(16'sh0801, 16'sh0000, 1'b0);
    send_offset(-16'sh0001, 16'sh0001, 1'b1);
    send_offset(16'sh0100, 16'sh0100, 1'b1);
    send_offset(16'sh0000, 16'sh0000, 1'b1);
    settle();
    set_regs(128000, 5171, 32767, 16777215);
    send_offset(16'sh7fff, -16'sh8000, 1'b0);
    send_offset(16'sh0010, 16'sh0020, 1'b0);
    send_offset(-16'sh4000, 16'sh3000, 1'b0);
    send_offset(16'sh0001, 16'sh0000, 1'b1);
    settle();
    set_regs(128000, 0, 32767, 16777215);
    send_offset(16'sh1000, 16'sh1000, 1'b0);
    send_offset(-16'sh0800, 16'sh0100, 1'b0);
    send_offset(16'sh0002, -16'sh0003, 1'b1);
    settle();
    set_regs(0, 0, 0, 0);
    send_offset(16'sh0001, 16'sh0001, 1'b0);
    send_offset(16'sh0000, 16'sh0000, 1'b1);
    settle();
    set_regs(35840, 512, 1, 11341);
    send_offset(16'sh0001, 16'sh0000, 1'b0);
    send_offset(16'sh0000, -16'sh0001, 1'b1);
    settle();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph != 3);
      if (ph == 0) set_regs(35840, 512, 2048, 11341);
      else set_regs($urandom_range(128000), $urandom_range(5171),
                    $urandom_range(1, 32767), $urandom_range(24'hffffff));
      if (ph == 2) begin
        // overfill the store; the final mark lands on a dropped offset
        random_run(MAX_NB + 3);
      end
      if (ph == 5) begin
        hold_req = 1'b1;
        random_run(MAX_NB);
      end
      for (int r = 0; r < 3; r++)
        random_run(($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6));
      settle();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sdd_pkg.sv
hdl/sdd_wgt.sv
hdl/sdd_dp.sv
hdl/sdd_ctrl.sv
hdl/sph_double_density_relaxation.sv
test/sdd_move_checker.sv
test/tb_sph_double_density_relaxation.sv
